// ===== sv/rcc_pkg.sv =====
// Shared types, register codes and calibration constants of the radiometric count calibration unit.
`default_nettype none

package rcc_pkg;

	localparam int OUT_W      = 18;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int GAIN_W     = 24;
	localparam int SPACE_W    = 16;
	localparam int MANT_W     = 32;
	localparam int FRAC_W     = 16;
	localparam int A_W        = 28;
	localparam int K_W        = 21;
	localparam int NUM_W      = 37;
	localparam int QUO_W      = 18;
	localparam int MUL_W      = 16;

	localparam logic [OUT_W-1:0] OUT_MAX = 18'h3FFFF;
	localparam logic [OUT_W-1:0] ONE_Q8  = 18'd256;

	localparam logic [CFG_IDX_W-1:0] REG_SATELLITE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BAND      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEFFS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPACE     = 3'd4;

	localparam logic [2:0] SAT_FIRST  = 3'd0;
	localparam logic [2:0] SAT_EAST   = 3'd1;
	localparam logic [2:0] SAT_WEST   = 3'd2;
	localparam logic [2:0] SAT_TABLED = 3'd3;
	localparam logic [2:0] SAT_FIFTH  = 3'd4;

	localparam logic [1:0] BAND_IR  = 2'd0;
	localparam logic [1:0] BAND_WV  = 2'd1;
	localparam logic [1:0] BAND_VIS = 2'd2;
	localparam logic [1:0] BAND_HRV = 2'd3;

	// Default gain (Q0.24) and space count (Q8.8) of the fifth satellite.
	localparam logic [GAIN_W-1:0]  FIFTH_IR_GAIN  = 24'd1241514;
	localparam logic [SPACE_W-1:0] FIFTH_IR_SPACE = 16'd1280;
	localparam logic [GAIN_W-1:0]  FIFTH_WV_GAIN  = 24'd130862;
	localparam logic [SPACE_W-1:0] FIFTH_WV_SPACE = 16'd1536;

	localparam logic [MUL_W-1:0] PCT_MUL  = 16'd25600;
	localparam logic [MUL_W-1:0] WEST_MUL = 16'd40704;
	localparam logic [OUT_W-1:0] WEST_OFS = 18'd40730;

	localparam int               EAST_KNEE = 79;
	localparam logic [OUT_W-1:0] EAST_BASE = 18'd163;
	localparam logic [OUT_W-1:0] EAST_OFS  = 18'd405;

	// ln(2) in Q0.32 and ln(2^32) in Q.16.
	localparam logic [31:0]    LN2_Q32    = 32'd2977044472;
	localparam logic [K_W-1:0] LN_2POW32  = 21'd1453635;

	typedef enum logic [2:0] {
		MODE_FALLBACK,
		MODE_PERCENT,
		MODE_EAST,
		MODE_WEST,
		MODE_LOG
	} mode_t;

	typedef enum logic [1:0] {
		LAW_FIRST_IR,
		LAW_FIRST_WV,
		LAW_FIFTH_IR,
		LAW_FIFTH_WV
	} law_t;

	// Control that travels with every pixel; done means the value is already final.
	typedef struct packed {
		mode_t            mode;
		law_t             law;
		logic             done;
		logic             clip;
		logic [OUT_W-1:0] val;
	} side_t;

	function automatic logic [A_W-1:0] law_a(input law_t law);
		logic [A_W-1:0] a;
		case (law)
			LAW_FIRST_IR: a = 28'd82283495;
			LAW_FIRST_WV: a = 28'd146373883;
			LAW_FIFTH_IR: a = 28'd83374899;
			LAW_FIFTH_WV: a = 28'd148432486;
			default:      a = 28'd82283495;
		endcase
		return a;
	endfunction

	// B plus ln(2^32), both in Q.16.
	function automatic logic [K_W-1:0] law_k(input law_t law);
		logic [K_W-1:0] b;
		case (law)
			LAW_FIRST_IR: b = 21'd456249;
			LAW_FIRST_WV: b = 21'd606057;
			LAW_FIFTH_IR: b = 21'd441372;
			LAW_FIFTH_WV: b = 21'd597190;
			default:      b = 21'd456249;
		endcase
		return b + LN_2POW32;
	endfunction

endpackage

`default_nettype wire

// ===== sv/rcc_sq_stage.sv =====
// One squaring step of the log2 fraction search: yields one fraction bit per stage.
`default_nettype none

module rcc_sq_stage #(
	parameter int FRAC_BIT = 15
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [rcc_pkg::MANT_W-1:0]   m_in,
	input  logic [rcc_pkg::FRAC_W-1:0]   frac_in,
	output logic [rcc_pkg::MANT_W-1:0]   m_s,
	output logic [rcc_pkg::FRAC_W-1:0]   frac_s
);
	import rcc_pkg::*;

	logic [2*MANT_W-1:0] sq;
	logic [MANT_W:0]     top;

	always_comb begin
		sq  = (2*MANT_W)'(m_in) * (2*MANT_W)'(m_in);
		top = sq[2*MANT_W-1:MANT_W-1];
	end

	// A square at or above 2.0 sets this bit and renormalizes by one place.
	always_ff @(posedge clk) begin
		if (en) begin
			if (top[MANT_W]) begin
				m_s    <= top[MANT_W:1];
				frac_s <= frac_in | (FRAC_W'(1) << FRAC_BIT);
			end else begin
				m_s    <= top[MANT_W-1:0];
				frac_s <= frac_in;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/rcc_div_step.sv =====
// One restoring division step of the temperature divider: one quotient bit per stage.
`default_nettype none

module rcc_div_step #(
	parameter int REM_W = 41,
	parameter int DEN_W = 23,
	parameter int SHIFT = 0
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [REM_W-1:0]           rem_in,
	input  logic [DEN_W-1:0]           den_in,
	input  logic [rcc_pkg::QUO_W-1:0]  quo_in,
	output logic [REM_W-1:0]           rem_s,
	output logic [DEN_W-1:0]           den_s,
	output logic [rcc_pkg::QUO_W-1:0]  quo_s
);
	import rcc_pkg::*;

	logic [REM_W-1:0] trial;

	assign trial = REM_W'(den_in) << SHIFT;

	always_ff @(posedge clk) begin
		if (en) begin
			den_s <= den_in;
			if (rem_in >= trial) begin
				rem_s <= rem_in - trial;
				quo_s <= quo_in | (QUO_W'(1) << SHIFT);
			end else begin
				rem_s <= rem_in;
				quo_s <= quo_in;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/radiometric_count_calibration_unit.sv =====
// Top level of the radiometric count calibration unit.
`default_nettype none

// Converts one image count per clock, when not stalled, into a calibrated Q10.8
// value (kelvin or percent albedo) for the satellite and band held in the
// configuration registers. The pipeline is 42 stages deep, and a new pixel can
// be taken in every cycle while nothing stalls. The depth is set by the log2
// fraction search (16 squaring stages, one 32x32 multiply each) and the
// temperature divider (18 restoring stages, one quotient bit each). A stall on
// the result side holds only the stages that carry a pixel, so empty stages
// keep filling behind it. The configuration port is always ready; registers are
// meant to be written only while no pixel is in flight. There is no memory and
// no clearing pass.
module radiometric_count_calibration_unit #(
	parameter int COUNT_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rcc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rcc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              pixel_valid,
	output logic                              pixel_stall,
	input  logic [COUNT_BITS-1:0]             pixel_count,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [rcc_pkg::OUT_W-1:0]         physical_value,
	output logic                              valid_res,
	output logic                              clipped
);
	import rcc_pkg::*;

	localparam int CMAX_I = (1 << COUNT_BITS) - 1;
	localparam logic [COUNT_BITS-1:0] CMAX = CMAX_I[COUNT_BITS-1:0];
	localparam int C8W = COUNT_BITS + 8;
	localparam int PW  = GAIN_W + C8W;
	localparam int LZW = $clog2(PW);
	localparam int XLW = LZW + FRAC_W;
	localparam int DW  = XLW + 2;
	localparam int RW  = (DW + QUO_W - 1 > NUM_W) ? DW + QUO_W - 1 : NUM_W;
	localparam int XW  = MUL_W + COUNT_BITS;
	localparam int MW  = XW - COUNT_BITS + 1;
	localparam int LPW = XW + MW;
	localparam int QCW = MW + COUNT_BITS;
	localparam int LNW = XLW + 32;
	localparam logic [MW-1:0] RECIP = MW'((64'd1 << XW) / CMAX_I);
	localparam logic [XW-1:0] HALF  = XW'(CMAX_I / 2);

	localparam int I_S1  = 0;
	localparam int I_S2  = 1;
	localparam int I_S3  = 2;
	localparam int I_S4  = 3;
	localparam int I_SQ0 = 4;
	localparam int I_LN  = I_SQ0 + FRAC_W;
	localparam int I_D   = I_LN + 1;
	localparam int I_N   = I_D + 1;
	localparam int I_DV0 = I_N + 1;
	localparam int I_OUT = I_DV0 + QUO_W;
	localparam int NS    = I_OUT + 1;

	// Configuration registers.
	logic [2:0]         sat_q;
	logic [1:0]         band_q;
	logic               coeffs_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [SPACE_W-1:0] space_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q    <= '0;
			band_q   <= '0;
			coeffs_q <= 1'b0;
			gain_q   <= '0;
			space_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SATELLITE: sat_q    <= cfg_data[2:0];
				REG_BAND:      band_q   <= cfg_data[1:0];
				REG_COEFFS:    coeffs_q <= cfg_data[0];
				REG_GAIN:      gain_q   <= cfg_data[GAIN_W-1:0];
				REG_SPACE:     space_q  <= cfg_data[SPACE_W-1:0];
				default: ;
			endcase
		end
	end

	// Valid bits and per-stage enables; a stage moves when it is empty or its successor moves.
	logic [NS-1:0] vld;
	logic [NS-1:0] vld_in;
	logic [NS-1:0] en;

	always_comb begin
		en[NS-1] = !vld[NS-1] || !result_stall;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !vld[k] || en[k+1];
		end
	end

	assign vld_in      = {vld[NS-2:0], pixel_valid};
	assign pixel_stall = !en[I_S1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (en[k]) begin
					vld[k] <= vld_in[k];
				end
			end
		end
	end

	// Stage 1: select the conversion, form the radiance offset, linear numerator and east map.
	mode_t              mode_c;
	law_t               law_c;
	logic [GAIN_W-1:0]  gain_c;
	logic [SPACE_W-1:0] space_c;
	logic [C8W-1:0]     c8_c;
	logic [C8W-1:0]     space_ext_c;
	logic               le0_c;
	logic [MUL_W-1:0]   lin_mul_c;
	logic [XW-1:0]      x_c;
	logic [OUT_W-1:0]   east_c;
	side_t              side_c;

	always_comb begin
		mode_c  = MODE_FALLBACK;
		law_c   = LAW_FIRST_IR;
		gain_c  = gain_q;
		space_c = space_q;
		case (sat_q)
			SAT_FIRST: begin
				if (band_q == BAND_IR && coeffs_q) begin
					mode_c = MODE_LOG;
					law_c  = LAW_FIRST_IR;
				end else if (band_q == BAND_WV && coeffs_q) begin
					mode_c = MODE_LOG;
					law_c  = LAW_FIRST_WV;
				end else if (band_q == BAND_VIS || band_q == BAND_HRV) begin
					mode_c = MODE_PERCENT;
				end
			end
			SAT_EAST: begin
				if (band_q == BAND_VIS) begin
					mode_c = MODE_PERCENT;
				end else if (band_q == BAND_IR) begin
					mode_c = MODE_EAST;
				end
			end
			SAT_WEST: begin
				if (band_q == BAND_VIS) begin
					mode_c = MODE_PERCENT;
				end else if (band_q == BAND_IR) begin
					mode_c = MODE_WEST;
				end
			end
			SAT_FIFTH: begin
				if (band_q == BAND_VIS) begin
					mode_c = MODE_PERCENT;
				end else if (band_q == BAND_IR) begin
					mode_c = MODE_LOG;
					law_c  = LAW_FIFTH_IR;
					if (!coeffs_q) begin
						gain_c  = FIFTH_IR_GAIN;
						space_c = FIFTH_IR_SPACE;
					end
				end else if (band_q == BAND_WV) begin
					mode_c = MODE_LOG;
					law_c  = LAW_FIFTH_WV;
					if (!coeffs_q) begin
						gain_c  = FIFTH_WV_GAIN;
						space_c = FIFTH_WV_SPACE;
					end
				end
			end
			default: ;
		endcase

		c8_c        = {pixel_count, 8'h00};
		space_ext_c = C8W'(space_c);
		le0_c       = c8_c <= space_ext_c;

		lin_mul_c = (mode_c == MODE_WEST) ? WEST_MUL : PCT_MUL;
		x_c       = XW'(lin_mul_c) * XW'(pixel_count) + HALF;

		if (pixel_count < EAST_KNEE) begin
			east_c = (OUT_W'(pixel_count) + EAST_BASE) << 8;
		end else begin
			east_c = (OUT_W'(pixel_count) + EAST_OFS) << 7;
		end

		side_c.mode = mode_c;
		side_c.law  = law_c;
		side_c.done = le0_c;
		side_c.clip = 1'b0;
		case (mode_c)
			MODE_FALLBACK: side_c.val = ONE_Q8;
			MODE_EAST:     side_c.val = east_c;
			default:       side_c.val = '0;
		endcase
	end

	side_t             side_s1;
	logic [GAIN_W-1:0] gain_s1;
	logic [C8W-1:0]    diff_s1;
	logic [XW-1:0]     x_s1;

	always_ff @(posedge clk) begin
		if (en[I_S1]) begin
			side_s1 <= side_c;
			gain_s1 <= gain_c;
			diff_s1 <= c8_c - space_ext_c;
			x_s1    <= x_c;
		end
	end

	// Stage 2: radiance product and reciprocal estimate of the linear quotient.
	logic [LPW-1:0] lp_c;
	side_t          side_s2;
	logic [PW-1:0]  p_s2;
	logic [MW-1:0]  qe_s2;
	logic [XW-1:0]  x_s2;

	assign lp_c = LPW'(x_s1) * LPW'(RECIP);

	always_ff @(posedge clk) begin
		if (en[I_S2]) begin
			side_s2 <= side_s1;
			p_s2    <= PW'(gain_s1) * PW'(diff_s1);
			qe_s2   <= lp_c[LPW-1 -: MW];
			x_s2    <= x_s1;
		end
	end

	// Stage 3: leading-one position of the product; back-multiply of the estimate.
	logic [LZW-1:0] lz_c;
	side_t          side_c3;

	always_comb begin
		lz_c = '0;
		for (int i = 0; i < PW; i++) begin
			if (p_s2[i]) begin
				lz_c = LZW'(PW - 1 - i);
			end
		end
		side_c3 = side_s2;
		if (p_s2 == '0) begin
			side_c3.done = 1'b1;
		end
	end

	side_t          side_s3;
	logic [PW-1:0]  p_s3;
	logic [LZW-1:0] lz_s3;
	logic [MW-1:0]  qe_s3;
	logic [QCW-1:0] qc_s3;
	logic [XW-1:0]  x_s3;

	always_ff @(posedge clk) begin
		if (en[I_S3]) begin
			side_s3 <= side_c3;
			p_s3    <= p_s2;
			lz_s3   <= lz_c;
			qe_s3   <= qe_s2;
			qc_s3   <= QCW'(qe_s2) * QCW'(CMAX);
			x_s3    <= x_s2;
		end
	end

	// Stage 4: normalize the mantissa to Q1.31; correct the linear quotient by one.
	logic [PW-1:0] pn_c;
	logic [XW-1:0] r_c;
	logic [MW-1:0] q_c;
	side_t         side_c4;

	always_comb begin
		pn_c = p_s3 << lz_s3;
		r_c  = x_s3 - XW'(qc_s3);
		q_c  = (r_c >= XW'(CMAX)) ? qe_s3 + MW'(1) : qe_s3;
		side_c4 = side_s3;
		case (side_s3.mode)
			MODE_PERCENT: side_c4.val = OUT_W'(q_c);
			MODE_WEST:    side_c4.val = OUT_W'(q_c) + WEST_OFS;
			default: ;
		endcase
	end

	side_t             side_s4;
	logic [MANT_W-1:0] m_s4;
	logic [LZW-1:0]    e_s4;

	always_ff @(posedge clk) begin
		if (en[I_S4]) begin
			side_s4 <= side_c4;
			m_s4    <= pn_c[PW-1 -: MANT_W];
			e_s4    <= LZW'(PW - 1) - lz_s3;
		end
	end

	// Stages 5 to 20: one fraction bit of log2 per squaring stage.
	logic [MANT_W-1:0] m_chain    [FRAC_W+1];
	logic [FRAC_W-1:0] frac_chain [FRAC_W+1];
	side_t             side_sq    [FRAC_W];
	logic [LZW-1:0]    e_sq       [FRAC_W];

	assign m_chain[0]    = m_s4;
	assign frac_chain[0] = '0;

	for (genvar k = 0; k < FRAC_W; k++) begin : g_sq
		rcc_sq_stage #(
			.FRAC_BIT(FRAC_W - 1 - k)
		) u_sq (
			.clk    (clk),
			.en     (en[I_SQ0 + k]),
			.m_in   (m_chain[k]),
			.frac_in(frac_chain[k]),
			.m_s    (m_chain[k+1]),
			.frac_s (frac_chain[k+1])
		);
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < FRAC_W; k++) begin
			if (en[I_SQ0 + k]) begin
				side_sq[k] <= (k == 0) ? side_s4 : side_sq[(k == 0) ? 0 : k - 1];
				e_sq[k]    <= (k == 0) ? e_s4    : e_sq[(k == 0) ? 0 : k - 1];
			end
		end
	end

	// Stage 21: natural log from log2, rounded.
	logic [XLW-1:0] xl_c;
	logic [LNW-1:0] lnp_c;
	side_t          side_s21;
	logic [XLW-1:0] lnv_s21;

	always_comb begin
		xl_c  = {e_sq[FRAC_W-1], frac_chain[FRAC_W]};
		lnp_c = LNW'(xl_c) * LNW'(LN2_Q32) + (LNW'(1) << 31);
	end

	always_ff @(posedge clk) begin
		if (en[I_LN]) begin
			side_s21 <= side_sq[FRAC_W-1];
			lnv_s21  <= lnp_c[LNW-1 -: XLW];
		end
	end

	// Stage 22: denominator D = B + ln(2^32) - ln(P), with its zero and negative cases.
	logic [DW-1:0] d_c;
	side_t         side_c22;

	always_comb begin
		d_c      = DW'(law_k(side_s21.law)) - DW'(lnv_s21);
		side_c22 = side_s21;
		if (side_s21.mode == MODE_LOG && !side_s21.done) begin
			if (d_c == '0) begin
				side_c22.done = 1'b1;
				side_c22.clip = 1'b1;
				side_c22.val  = OUT_MAX;
			end else if (d_c[DW-1]) begin
				side_c22.done = 1'b1;
				side_c22.clip = 1'b1;
				side_c22.val  = '0;
			end
		end
	end

	side_t         side_s22;
	logic [DW-1:0] d_s22;

	always_ff @(posedge clk) begin
		if (en[I_D]) begin
			side_s22 <= side_c22;
			d_s22    <= d_c;
		end
	end

	// Stage 23: rounded numerator and the check that the quotient fits in 18 bits.
	logic [NUM_W-1:0] num_c;
	logic [DW-2:0]    den_c;
	side_t            side_c23;

	always_comb begin
		den_c    = d_s22[DW-2:0];
		num_c    = (NUM_W'(law_a(side_s22.law)) << 8) + NUM_W'(d_s22[DW-1:1]);
		side_c23 = side_s22;
		if (side_s22.mode == MODE_LOG && !side_s22.done &&
		    RW'(num_c) >= (RW'(den_c) << QUO_W)) begin
			side_c23.done = 1'b1;
			side_c23.clip = 1'b1;
			side_c23.val  = OUT_MAX;
		end
	end

	side_t         side_s23;
	logic [RW-1:0] num_s23;
	logic [DW-2:0] den_s23;

	always_ff @(posedge clk) begin
		if (en[I_N]) begin
			side_s23 <= side_c23;
			num_s23  <= RW'(num_c);
			den_s23  <= den_c;
		end
	end

	// Stages 24 to 41: restoring division, most significant quotient bit first.
	logic [RW-1:0]    rem_chain [QUO_W+1];
	logic [DW-2:0]    den_chain [QUO_W+1];
	logic [QUO_W-1:0] quo_chain [QUO_W+1];
	side_t            side_dv   [QUO_W];

	assign rem_chain[0] = num_s23;
	assign den_chain[0] = den_s23;
	assign quo_chain[0] = '0;

	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		rcc_div_step #(
			.REM_W(RW),
			.DEN_W(DW - 1),
			.SHIFT(QUO_W - 1 - k)
		) u_div (
			.clk   (clk),
			.en    (en[I_DV0 + k]),
			.rem_in(rem_chain[k]),
			.den_in(den_chain[k]),
			.quo_in(quo_chain[k]),
			.rem_s (rem_chain[k+1]),
			.den_s (den_chain[k+1]),
			.quo_s (quo_chain[k+1])
		);
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < QUO_W; k++) begin
			if (en[I_DV0 + k]) begin
				side_dv[k] <= (k == 0) ? side_s23 : side_dv[(k == 0) ? 0 : k - 1];
			end
		end
	end

	// Stage 42: output register.
	side_t            side_fin;
	logic [OUT_W-1:0] value_s42;
	logic             valid_s42;
	logic             clip_s42;

	assign side_fin = side_dv[QUO_W-1];

	always_ff @(posedge clk) begin
		if (en[I_OUT]) begin
			if (side_fin.mode == MODE_LOG && !side_fin.done) begin
				value_s42 <= OUT_W'(quo_chain[QUO_W]);
			end else begin
				value_s42 <= side_fin.val;
			end
			valid_s42 <= side_fin.mode != MODE_FALLBACK;
			clip_s42  <= side_fin.clip;
		end
	end

	assign result_valid   = vld[I_OUT];
	assign physical_value = value_s42;
	assign valid_res      = valid_s42;
	assign clipped        = clip_s42;

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench of the radiometric count calibration unit.
`timescale 1ns / 1ps

module tb;
	import rcc_pkg::*;

	localparam int CNT_W = 8;
	localparam int CMAX = (1 << CNT_W) - 1;
	localparam int DRAIN_CYCLES = 60;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [OUT_W-1:0] value;
		logic             vld;
		logic             clip;
	} calib_t;

	typedef struct {
		logic [2:0]  sat;
		logic [1:0]  band;
		logic        cs;
		logic [23:0] gain;
		logic [15:0] space;
		logic [7:0]  count;
		logic        known;
		calib_t      want;
	} pix_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic pixel_valid = 1'b0;
	logic pixel_stall;
	logic [CNT_W-1:0] pixel_count = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [OUT_W-1:0] physical_value;
	logic valid_res;
	logic clipped;

	// Predictor copy of the configuration registers.
	logic [2:0] sat_q = '0;
	logic [1:0] band_q = '0;
	logic coeffs_q = 1'b0;
	logic [23:0] gain_q = '0;
	logic [15:0] space_q = '0;

	calib_t pending_calib[$];
	int mismatches = 0;
	int accepted_pixels = 0;
	int results_seen = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_off = 1'b0;
	bit timed_out = 1'b0;

	always #5 clk = ~clk;

	radiometric_count_calibration_unit #(.COUNT_BITS(CNT_W)) DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
		.pixel_count(pixel_count),
		.result_valid(result_valid), .result_stall(result_stall),
		.physical_value(physical_value), .valid_res(valid_res), .clipped(clipped)
	);

	function automatic logic [63:0] log2_fixed(input logic [63:0] p);
		int e;
		logic [63:0] m;
		logic [63:0] frac;
		e = 0;
		frac = 0;
		while (e < 63 && (p >> (e + 1)) != 0)
			e++;
		if (e >= 31)
			m = p >> (e - 31);
		else
			m = p << (31 - e);
		for (int k = 15; k >= 0; k--) begin
			m = (m * m) >> 31;
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				frac[k] = 1'b1;
			end
		end
		return (64'(e) << 16) | frac;
	endfunction

	function automatic logic [63:0] ln_fixed(input logic [63:0] x);
		logic [127:0] prod;
		prod = 128'(x) * 128'(LN2_Q32) + (128'd1 << 31);
		return 64'(prod >> 32);
	endfunction

	function automatic calib_t temperature_law(input logic [7:0] cnt, input logic [63:0] gain,
			input logic [63:0] space, input logic [63:0] a_q16, input logic [63:0] b_q16);
		calib_t r;
		logic [63:0] c8;
		logic [63:0] p;
		longint d;
		logic [63:0] t;
		r = '{value: '0, vld: 1'b1, clip: 1'b0};
		c8 = 64'(cnt) << 8;
		if (c8 <= space)
			return r;
		p = gain * (c8 - space);
		if (p == 0)
			return r;
		d = longint'(b_q16 + ln_fixed(64'd32 << 16)) - longint'(ln_fixed(log2_fixed(p)));
		if (d == 0) begin
			r.value = OUT_MAX;
			r.clip = 1'b1;
		end else if (d < 0) begin
			r.clip = 1'b1;
		end else begin
			t = ((a_q16 << 8) + (64'(d) >> 1)) / 64'(d);
			if (t > 64'(OUT_MAX)) begin
				r.value = OUT_MAX;
				r.clip = 1'b1;
			end else begin
				r.value = t[OUT_W-1:0];
			end
		end
		return r;
	endfunction

	function automatic calib_t calibrate(input logic [7:0] cnt);
		calib_t r;
		int c;
		logic [63:0] g;
		logic [63:0] s;
		c = int'(cnt);
		g = 64'(gain_q);
		s = 64'(space_q);
		r = '{value: ONE_Q8, vld: 1'b0, clip: 1'b0};
		if (sat_q == SAT_FIRST) begin
			if (band_q == BAND_IR && coeffs_q)
				r = temperature_law(cnt, g, s, 82283495, 456249);
			else if (band_q == BAND_WV && coeffs_q)
				r = temperature_law(cnt, g, s, 146373883, 606057);
			else if (band_q >= BAND_VIS)
				r = '{value: OUT_W'((25600 * c + CMAX / 2) / CMAX), vld: 1'b1, clip: 1'b0};
		end else if (sat_q == SAT_EAST || sat_q == SAT_WEST || sat_q == SAT_FIFTH) begin
			if (band_q == BAND_VIS)
				r = '{value: OUT_W'((25600 * c + CMAX / 2) / CMAX), vld: 1'b1, clip: 1'b0};
			else if (band_q == BAND_IR && sat_q == SAT_EAST)
				r = '{value: OUT_W'((c < 79) ? ((163 + c) << 8) : ((c + 405) << 7)),
					vld: 1'b1, clip: 1'b0};
			else if (band_q == BAND_IR && sat_q == SAT_WEST)
				r = '{value: OUT_W'(40730 + (40704 * c + CMAX / 2) / CMAX),
					vld: 1'b1, clip: 1'b0};
			else if (band_q == BAND_IR && sat_q == SAT_FIFTH) begin
				if (!coeffs_q) begin
					g = 64'(FIFTH_IR_GAIN);
					s = 64'(FIFTH_IR_SPACE);
				end
				r = temperature_law(cnt, g, s, 83374899, 441372);
			end else if (band_q == BAND_WV && sat_q == SAT_FIFTH) begin
				if (!coeffs_q) begin
					g = 64'(FIFTH_WV_GAIN);
					s = 64'(FIFTH_WV_SPACE);
				end
				r = temperature_law(cnt, g, s, 148432486, 597190);
			end
		end
		return r;
	endfunction

	function automatic pix_row_t mk_row(input logic [2:0] sat, input logic [1:0] band,
			input logic cs, input logic [23:0] gain, input logic [15:0] space,
			input logic [7:0] count, input logic known, input calib_t want);
		pix_row_t row;
		row.sat = sat;
		row.band = band;
		row.cs = cs;
		row.gain = gain;
		row.space = space;
		row.count = count;
		row.known = known;
		row.want = want;
		return row;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SATELLITE: sat_q = val[2:0];
			REG_BAND:      band_q = val[1:0];
			REG_COEFFS:    coeffs_q = val[0];
			REG_GAIN:      gain_q = val[23:0];
			REG_SPACE:     space_q = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic setup(input logic [2:0] sat, input logic [1:0] band, input logic cs,
			input logic [23:0] gain, input logic [15:0] space);
		write_reg(REG_SATELLITE, CFG_DATA_W'(sat));
		write_reg(REG_BAND, CFG_DATA_W'(band));
		write_reg(REG_COEFFS, CFG_DATA_W'(cs));
		write_reg(REG_GAIN, CFG_DATA_W'(gain));
		write_reg(REG_SPACE, CFG_DATA_W'(space));
	endtask

	// Waits with the input side quiet until the pipeline has emptied.
	task automatic drain();
		while (pending_calib.size() != 0 && !timed_out)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Offers one pixel request; valid stays high across back-to-back requests.
	task automatic send_pixel(input logic [7:0] cnt, input logic known, input calib_t want);
		calib_t pred;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			pixel_valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		pixel_valid <= 1'b1;
		pixel_count <= cnt;
		do @(posedge clk); while (pixel_stall);
		pred = calibrate(cnt);
		if (known && pred != want && mismatches < 10)
			$display("table row disagrees with predictor: count %0d", cnt);
		pending_calib.push_back(known ? want : pred);
		accepted_pixels++;
	endtask

	task automatic end_burst();
		@(negedge clk);
		pixel_valid <= 1'b0;
	endtask

	task automatic random_phase(input int n);
		logic [2:0] sat;
		logic [1:0] band;
		logic [15:0] space;
		sat = 3'($urandom_range(7));
		if ($urandom_range(3) != 0)
			sat = ($urandom_range(1)) ? SAT_FIRST : SAT_FIFTH;
		band = 2'($urandom);
		space = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4095));
		setup(sat, band, 1'($urandom), 24'($urandom), space);
		for (int i = 0; i < n; i++)
			send_pixel(8'($urandom), 1'b0, '0);
		end_burst();
		drain();
	endtask

	// Result side: stalls at random, or holds off for a long stretch on request.
	always @(negedge clk) begin
		if (hold_off)
			result_stall <= 1'b1;
		else
			result_stall <= (recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		calib_t got;
		calib_t want;
		if (arst_n && result_valid && !result_stall) begin
			got = '{value: physical_value, vld: valid_res, clip: clipped};
			results_seen++;
			if (pending_calib.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %0d/%0b/%0b", got.value, got.vld, got.clip);
			end else begin
				want = pending_calib.pop_front();
				if (got != want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
							want.value, want.vld, want.clip, got.value, got.vld, got.clip);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((pixel_valid && !pixel_stall) || (result_valid && !result_stall) || cfg_valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("watchdog expired");
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		pix_row_t rows[$];
		logic [2:0] cur_sat;
		logic [1:0] cur_band;
		logic cur_cs;
		logic [23:0] cur_gain;
		logic [15:0] cur_space;

		// After reset the first satellite IR band is uncalibrated and falls back.
		rows.push_back(mk_row(SAT_FIRST, BAND_IR, 1'b0, 24'd0, 16'd0,
			8'd0, 1'b1, '{ONE_Q8, 1'b0, 1'b0}));
		rows.push_back(mk_row(SAT_FIRST, BAND_IR, 1'b0, 24'd0, 16'd0,
			8'd255, 1'b1, '{ONE_Q8, 1'b0, 1'b0}));
		// Visible percent map extremes.
		rows.push_back(mk_row(SAT_FIRST, BAND_VIS, 1'b0, 24'd0, 16'd0,
			8'd0, 1'b1, '{18'd0, 1'b1, 1'b0}));
		rows.push_back(mk_row(SAT_FIRST, BAND_VIS, 1'b0, 24'd0, 16'd0,
			8'd255, 1'b1, '{18'd25600, 1'b1, 1'b0}));
		// East piecewise map on both sides of the knee.
		rows.push_back(mk_row(SAT_EAST, BAND_IR, 1'b0, 24'd0, 16'd0,
			8'd0, 1'b1, '{18'd41728, 1'b1, 1'b0}));
		rows.push_back(mk_row(SAT_EAST, BAND_IR, 1'b0, 24'd0, 16'd0,
			8'd78, 1'b1, '{18'd61696, 1'b1, 1'b0}));
		rows.push_back(mk_row(SAT_EAST, BAND_IR, 1'b0, 24'd0, 16'd0,
			8'd79, 1'b1, '{18'd61952, 1'b1, 1'b0}));
		rows.push_back(mk_row(SAT_EAST, BAND_IR, 1'b0, 24'd0, 16'd0,
			8'd255, 1'b1, '{18'd84480, 1'b1, 1'b0}));
		// West linear map.
		rows.push_back(mk_row(SAT_WEST, BAND_IR, 1'b0, 24'd0, 16'd0,
			8'd0, 1'b1, '{18'd40730, 1'b1, 1'b0}));
		rows.push_back(mk_row(SAT_WEST, BAND_IR, 1'b0, 24'd0, 16'd0,
			8'd255, 1'b1, '{18'd81434, 1'b1, 1'b0}));
		// Tabled satellite and unsupported ids fall back.
		rows.push_back(mk_row(SAT_TABLED, BAND_IR, 1'b1, 24'hFFFFFF, 16'hFFFF,
			8'd100, 1'b1, '{ONE_Q8, 1'b0, 1'b0}));
		rows.push_back(mk_row(3'd7, BAND_HRV, 1'b1, 24'hFFFFFF, 16'd0,
			8'd200, 1'b1, '{ONE_Q8, 1'b0, 1'b0}));
		// Log law: zero radiance, default coefficients, and the largest radiance.
		rows.push_back(mk_row(SAT_FIFTH, BAND_IR, 1'b0, 24'd0, 16'd0,
			8'd0, 1'b1, '{18'd0, 1'b1, 1'b0}));
		rows.push_back(mk_row(SAT_FIFTH, BAND_IR, 1'b0, 24'd0, 16'd0,
			8'd5, 1'b1, '{18'd0, 1'b1, 1'b0}));
		rows.push_back(mk_row(SAT_FIFTH, BAND_IR, 1'b0, 24'd0, 16'd0, 8'd128, 1'b0, '0));
		rows.push_back(mk_row(SAT_FIFTH, BAND_IR, 1'b0, 24'd0, 16'd0, 8'd255, 1'b0, '0));
		rows.push_back(mk_row(SAT_FIFTH, BAND_WV, 1'b0, 24'd0, 16'd0,
			8'd6, 1'b1, '{18'd0, 1'b1, 1'b0}));
		rows.push_back(mk_row(SAT_FIFTH, BAND_WV, 1'b0, 24'd0, 16'd0, 8'd170, 1'b0, '0));
		rows.push_back(mk_row(SAT_FIRST, BAND_IR, 1'b1, 24'hFFFFFF, 16'd0, 8'd1, 1'b0, '0));
		rows.push_back(mk_row(SAT_FIRST, BAND_IR, 1'b1, 24'hFFFFFF, 16'd0, 8'd255, 1'b0, '0));
		rows.push_back(mk_row(SAT_FIRST, BAND_WV, 1'b1, 24'd0, 16'hFFFF,
			8'd255, 1'b1, '{18'd0, 1'b1, 1'b0}));
		// Water vapour on the east satellite is unsupported.
		rows.push_back(mk_row(SAT_EAST, BAND_WV, 1'b0, 24'd0, 16'd0,
			8'd90, 1'b1, '{ONE_Q8, 1'b0, 1'b0}));

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Rows that share a configuration run as one burst; the block is empty between them.
		cur_sat = '0;
		cur_band = '0;
		cur_cs = 1'b0;
		cur_gain = '0;
		cur_space = '0;
		foreach (rows[i]) begin
			if (rows[i].sat != cur_sat || rows[i].band != cur_band || rows[i].cs != cur_cs ||
			    rows[i].gain != cur_gain || rows[i].space != cur_space) begin
				end_burst();
				drain();
				setup(rows[i].sat, rows[i].band, rows[i].cs, rows[i].gain, rows[i].space);
				cur_sat = rows[i].sat;
				cur_band = rows[i].band;
				cur_cs = rows[i].cs;
				cur_gain = rows[i].gain;
				cur_space = rows[i].space;
			end
			send_pixel(rows[i].count, rows[i].known, rows[i].want);
		end
		end_burst();
		drain();

		// Long receiver hold-off with the sender still offering, so the input stalls.
		setup(SAT_FIFTH, BAND_IR, 1'b1, 24'd4000000, 16'd512);
		hold_off = 1'b1;
		fork
			begin
				for (int i = 0; i < 80; i++)
					send_pixel(8'($urandom), 1'b0, '0);
				end_burst();
			end
			begin
				repeat (300) @(posedge clk);
				hold_off = 1'b0;
			end
		join
		drain();

		send_idle_pct = 32;
		recv_idle_pct = 77;
		for (int ph = 0; ph < 6; ph++)
			random_phase(30);
		send_idle_pct = 77;
		recv_idle_pct = 32;
		for (int ph = 0; ph < 6; ph++)
			random_phase(30);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int ph = 0; ph < 6; ph++)
			random_phase(30);

		drain();
		$display("covered %0d pixels and %0d results over all satellite and band selections",
			accepted_pixels, results_seen);
		$display("log, piecewise, linear, percent and fallback paths with stalls on both sides");
		if (mismatches == 0 && pending_calib.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/rcc_pkg.sv
sv/rcc_sq_stage.sv
sv/rcc_div_step.sv
sv/radiometric_count_calibration_unit.sv
tb/tb.sv
